[src/rrect_pkg.sv]
`default_nettype none
package rrect_pkg;

   // field widths
   localparam int CoordW   = 21;
   localparam int XyzW     = 3 * CoordW;
   localparam int LenW     = 40;
   localparam int EpsW     = 16;
   localparam int DistW    = 32;
   localparam int NumW     = 45;
   localparam int DenW     = 44;
   localparam int MagW     = 44;
   localparam int RemW     = 44;
   localparam int DivStages       = 8;
   localparam int DivBitsPerStage = DistW / DivStages;

   // register indexes
   localparam logic [2:0] RegCorner     = 3'd0;
   localparam logic [2:0] RegEdgeA      = 3'd1;
   localparam logic [2:0] RegEdgeB      = 3'd2;
   localparam logic [2:0] RegNormal     = 3'd3;
   localparam logic [2:0] RegEdgeALenSq = 3'd4;
   localparam logic [2:0] RegEdgeBLenSq = 3'd5;
   localparam logic [2:0] RegMinDist    = 3'd6;
   localparam logic [2:0] RegShadowEn   = 3'd7;

   localparam logic [EpsW-1:0] MinDistReset = EpsW'(66);

   typedef logic signed [CoordW-1:0] coord_type;

   // one beat inside the divider stages
   typedef struct packed {
      logic                vld;
      logic                miss;
      logic                sat;
      logic                shadow;
      coord_type [2:0]     o;
      coord_type [2:0]     d;
      logic [MagW-1:0]     ad;
      logic [RemW-1:0]     rem;
      logic [DistW-1:0]    low;
      logic [DistW-1:0]    q;
   } div_type;

   // clamp a wide signed coordinate into 21 bits
   function automatic coord_type sat21(input logic signed [38:0] v);
      logic signed [38:0] lo;
      logic signed [38:0] hi;
      lo = 39'sd0 - 39'sd1048576;
      hi = 39'sd1048575;
      if (v < lo) begin
         sat21 = coord_type'(lo);
      end else if (v > hi) begin
         sat21 = coord_type'(hi);
      end else begin
         sat21 = coord_type'(v);
      end
   endfunction

endpackage
`default_nettype wire

[src/rrect_req_if.sv]
`default_nettype none
interface rrect_req_if;
   logic                    valid;
   logic                    ready;
   logic                    req_type;
   logic signed [20:0]      origin_x;
   logic signed [20:0]      origin_y;
   logic signed [20:0]      origin_z;
   logic signed [20:0]      dir_x;
   logic signed [20:0]      dir_y;
   logic signed [20:0]      dir_z;
   modport source (output valid, req_type, origin_x, origin_y, origin_z,
                   dir_x, dir_y, dir_z, input ready);
   modport sink   (input valid, req_type, origin_x, origin_y, origin_z,
                   dir_x, dir_y, dir_z, output ready);
endinterface
`default_nettype wire

[src/rrect_rsp_if.sv]
`default_nettype none
interface rrect_rsp_if;
   logic                    valid;
   logic                    ready;
   logic                    is_hit;
   logic [31:0]             hit_distance;
   logic signed [20:0]      point_x;
   logic signed [20:0]      point_y;
   logic signed [20:0]      point_z;
   modport source (output valid, is_hit, hit_distance, point_x, point_y, point_z,
                   input ready);
   modport sink   (input valid, is_hit, hit_distance, point_x, point_y, point_z,
                   output ready);
endinterface
`default_nettype wire

[src/rrect_div_stage.sv]
`default_nettype none
// Four restoring-division steps and the register behind them.
module rrect_div_stage import rrect_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire div_type stage_in,
   output div_type      stage_out
);

   div_type stage_in_c;
   div_type stage_ff;

   // shift in one dividend bit, subtract when the divisor fits
   always_comb begin
      logic [RemW:0] r;
      logic          qb;
      stage_in_c = stage_in;
      for (int k = 0; k < DivBitsPerStage; k++) begin
         r  = {stage_in_c.rem, stage_in_c.low[DistW-1]};
         qb = 1'b0;
         stage_in_c.low = stage_in_c.low << 1;
         if (r >= {1'b0, stage_in_c.ad}) begin
            r  = r - {1'b0, stage_in_c.ad};
            qb = 1'b1;
         end
         stage_in_c.rem = r[RemW-1:0];
         stage_in_c.q   = {stage_in_c.q[DistW-2:0], qb};
      end
      // reset empties the stage
      if (reset) begin
         stage_in_c.vld = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load || reset) begin
         stage_ff <= stage_in_c;
      end
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

[src/ray_rectangle_intersect.sv]
`default_nettype none
// Ray against one configured rectangle.
//
// req: one ray per beat (req_type, origin, direction). rsp: one result
// beat per ray, in order (is_hit, hit_distance, hit point). csr_*: plain
// write port for the rectangle registers; write only while no ray is in
// flight.
//
// There are 15 register stages: a req beat passes stages 1 to 3, the eight
// divider stages and stages 12 to 15 to the output register. Throughput is
// one ray per cycle while rsp.ready keeps up: the plane distance quotient
// comes from an eight-stage divider producing four quotient bits per stage.
//
// Every stage holds its own valid bit and loads whenever it is empty or
// the stage after it moves, so bubbles close up and a result waiting on
// rsp does not block req until the whole pipeline is full. When rsp.ready
// stays low, beats pile up behind the output register and nothing is lost.
//
// Synchronous reset empties the pipeline and loads the register defaults
// (all geometry zero, min_distance 66, shadows enabled).
module ray_rectangle_intersect import rrect_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   rrect_req_if.sink         req,
   rrect_rsp_if.source       rsp,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [62:0]  csr_wdata
);

   // configuration registers
   logic [XyzW-1:0] corner_ff, edge_a_ff, edge_b_ff, normal_ff;
   logic [LenW-1:0] len_a_ff, len_b_ff;
   logic [EpsW-1:0] min_dist_ff;
   logic            shadow_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff    <= '0;
         edge_a_ff    <= '0;
         edge_b_ff    <= '0;
         normal_ff    <= '0;
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         min_dist_ff  <= MinDistReset;
         shadow_en_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            RegCorner:     corner_ff    <= csr_wdata;
            RegEdgeA:      edge_a_ff    <= csr_wdata;
            RegEdgeB:      edge_b_ff    <= csr_wdata;
            RegNormal:     normal_ff    <= csr_wdata;
            RegEdgeALenSq: len_a_ff     <= csr_wdata[LenW-1:0];
            RegEdgeBLenSq: len_b_ff     <= csr_wdata[LenW-1:0];
            RegMinDist:    min_dist_ff  <= csr_wdata[EpsW-1:0];
            RegShadowEn:   shadow_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   coord_type c [3];
   coord_type ea [3];
   coord_type eb [3];
   coord_type n [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c[i]  = coord_type'(corner_ff[(2-i)*CoordW +: CoordW]);
         ea[i] = coord_type'(edge_a_ff[(2-i)*CoordW +: CoordW]);
         eb[i] = coord_type'(edge_b_ff[(2-i)*CoordW +: CoordW]);
         n[i]  = coord_type'(normal_ff[(2-i)*CoordW +: CoordW]);
      end
   end

   // stage advance chain
   logic    adv1, adv2, adv3, adv12, adv13, adv14, adv15;
   logic    adv_d [DivStages];
   div_type div_in [DivStages];
   div_type div_out [DivStages];
   logic    v1_ff, v2_ff, v3_ff, v12_ff, v13_ff, v14_ff, v15_ff;

   assign adv15 = !v15_ff || rsp.ready;
   assign adv14 = !v14_ff || adv15;
   assign adv13 = !v13_ff || adv14;
   assign adv12 = !v12_ff || adv13;
   always_comb begin
      adv_d[DivStages-1] = !div_out[DivStages-1].vld || adv12;
      for (int k = DivStages-2; k >= 0; k--) begin
         adv_d[k] = !div_out[k].vld || adv_d[k+1];
      end
   end
   assign adv3 = !v3_ff || adv_d[0];
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req.ready = adv1;

   // stage 1: per-axis products for numerator and denominator
   logic signed [42:0] nump1_in [3], nump1_ff [3];
   logic signed [41:0] denp1_in [3], denp1_ff [3];
   coord_type          o_in [3], d_in [3];
   coord_type          o1_ff [3], d1_ff [3];
   logic               shadow1_ff, miss1_ff;

   always_comb begin
      logic signed [21:0] dif;
      o_in[0] = req.origin_x; o_in[1] = req.origin_y; o_in[2] = req.origin_z;
      d_in[0] = req.dir_x;    d_in[1] = req.dir_y;    d_in[2] = req.dir_z;
      for (int i = 0; i < 3; i++) begin
         dif         = 22'(c[i]) - 22'(o_in[i]);
         nump1_in[i] = 43'(dif) * 43'(n[i]);
         denp1_in[i] = 42'(d_in[i]) * 42'(n[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv1) begin
         v1_ff <= req.valid;
      end
      if (adv1) begin
         nump1_ff   <= nump1_in;
         denp1_ff   <= denp1_in;
         o1_ff      <= o_in;
         d1_ff      <= d_in;
         shadow1_ff <= req.req_type;
         miss1_ff   <= req.req_type && !shadow_en_ff;
      end
   end

   // stage 2: dot product sums
   logic signed [NumW-1:0] num2_ff;
   logic signed [DenW-1:0] den2_ff;
   coord_type              o2_ff [3], d2_ff [3];
   logic                   shadow2_ff, miss2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv2) begin
         v2_ff <= v1_ff;
      end
      if (adv2) begin
         num2_ff    <= NumW'(nump1_ff[0]) + NumW'(nump1_ff[1]) + NumW'(nump1_ff[2]);
         den2_ff    <= DenW'(denp1_ff[0]) + DenW'(denp1_ff[1]) + DenW'(denp1_ff[2]);
         o2_ff      <= o1_ff;
         d2_ff      <= d1_ff;
         shadow2_ff <= shadow1_ff;
         miss2_ff   <= miss1_ff;
      end
   end

   // stage 3: magnitudes, sign test, saturation test, divider setup
   logic [MagW-1:0] an_c, ad_c;
   div_type         div3_in, div3_ff;

   always_comb begin
      logic [NumW-1:0] an_w;
      logic [DenW-1:0] ad_w;
      an_w = num2_ff[NumW-1] ? NumW'(-num2_ff) : NumW'(num2_ff);
      ad_w = den2_ff[DenW-1] ? DenW'(-den2_ff) : DenW'(den2_ff);
      an_c = an_w[MagW-1:0];
      ad_c = ad_w;
      div3_in.vld    = v2_ff && !reset;
      div3_in.miss   = miss2_ff || (den2_ff == '0) || (num2_ff == '0)
                       || (num2_ff[NumW-1] != den2_ff[DenW-1]);
      // exact saturation compare: an*2^16 >= ad*2^32
      div3_in.sat    = {16'b0, an_c} >= {ad_c, 16'b0};
      div3_in.shadow = shadow2_ff;
      for (int i = 0; i < 3; i++) begin
         div3_in.o[i] = o2_ff[i];
         div3_in.d[i] = d2_ff[i];
      end
      div3_in.ad  = ad_c;
      div3_in.rem = RemW'(an_c[MagW-1:16]);
      div3_in.low = {an_c[15:0], 16'b0};
      div3_in.q   = '0;
   end

   always_ff @(posedge clock) begin
      if (adv3 || reset) begin
         div3_ff <= div3_in;
      end
   end
   assign v3_ff = div3_ff.vld;

   // divider stages
   assign div_in[0] = div3_ff;
   for (genvar k = 0; k < DivStages; k++) begin : g_div
      if (k > 0) begin : g_link
         assign div_in[k] = div_out[k-1];
      end
      rrect_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .load      (adv_d[k]),
         .stage_in  (div_in[k]),
         .stage_out (div_out[k])
      );
   end

   // stage 12: final t, epsilon test, t*d
   div_type            dq;
   logic [DistW-1:0]   t_c;
   logic signed [53:0] td_in [3], td12_ff [3];
   logic [DistW-1:0]   t12_ff;
   coord_type          o12_ff [3];
   logic               shadow12_ff, miss12_ff;

   assign dq  = div_out[DivStages-1];
   assign t_c = dq.sat ? '1 : dq.q;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         td_in[i] = $signed({1'b0, t_c}) * 54'($signed(dq.d[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v12_ff <= 1'b0;
      end else if (adv12) begin
         v12_ff <= dq.vld;
      end
      if (adv12) begin
         t12_ff      <= t_c;
         td12_ff     <= td_in;
         for (int i = 0; i < 3; i++) begin
            o12_ff[i] <= dq.o[i];
         end
         shadow12_ff <= dq.shadow;
         miss12_ff   <= dq.miss || (t_c <= {16'b0, min_dist_ff});
      end
   end

   // stage 13: hit point and offset from the corner
   logic signed [38:0] p_in [3], p13_ff [3];
   logic signed [39:0] off_in [3], off13_ff [3];
   logic [DistW-1:0]   t13_ff;
   logic               shadow13_ff, miss13_ff;

   always_comb begin
      logic signed [53:0] sh;
      for (int i = 0; i < 3; i++) begin
         sh        = td12_ff[i] >>> 16;
         p_in[i]   = 39'(o12_ff[i]) + $signed(sh[38:0]);
         off_in[i] = 40'(p_in[i]) - 40'(c[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v13_ff <= 1'b0;
      end else if (adv13) begin
         v13_ff <= v12_ff;
      end
      if (adv13) begin
         p13_ff      <= p_in;
         off13_ff    <= off_in;
         t13_ff      <= t12_ff;
         shadow13_ff <= shadow12_ff;
         miss13_ff   <= miss12_ff;
      end
   end

   // stage 14: projection products on both edges
   logic signed [60:0] pa_in [3], pb_in [3], pa14_ff [3], pb14_ff [3];
   logic signed [38:0] p14_ff [3];
   logic [DistW-1:0]   t14_ff;
   logic               shadow14_ff, miss14_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pa_in[i] = 61'(off13_ff[i]) * 61'(ea[i]);
         pb_in[i] = 61'(off13_ff[i]) * 61'(eb[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v14_ff <= 1'b0;
      end else if (adv14) begin
         v14_ff <= v13_ff;
      end
      if (adv14) begin
         pa14_ff     <= pa_in;
         pb14_ff     <= pb_in;
         p14_ff      <= p13_ff;
         t14_ff      <= t13_ff;
         shadow14_ff <= shadow13_ff;
         miss14_ff   <= miss13_ff;
      end
   end

   // stage 15: bounds test and output register
   logic signed [62:0] pa_c, pb_c;
   logic               hit_c;
   logic               hit15_ff;
   logic [DistW-1:0]   dist15_ff;
   coord_type          pt15_ff [3];

   assign pa_c  = 63'(pa14_ff[0]) + 63'(pa14_ff[1]) + 63'(pa14_ff[2]);
   assign pb_c  = 63'(pb14_ff[0]) + 63'(pb14_ff[1]) + 63'(pb14_ff[2]);
   assign hit_c = !miss14_ff
                  && !pa_c[62] && ($unsigned(pa_c) <= 63'(len_a_ff))
                  && !pb_c[62] && ($unsigned(pb_c) <= 63'(len_b_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         v15_ff <= 1'b0;
      end else if (adv15) begin
         v15_ff <= v14_ff;
      end
      if (adv15) begin
         hit15_ff  <= hit_c;
         dist15_ff <= hit_c ? t14_ff : '0;
         for (int i = 0; i < 3; i++) begin
            pt15_ff[i] <= (hit_c && !shadow14_ff) ? sat21(p14_ff[i]) : '0;
         end
      end
   end

   assign rsp.valid        = v15_ff;
   assign rsp.is_hit       = hit15_ff;
   assign rsp.hit_distance = dist15_ff;
   assign rsp.point_x      = pt15_ff[0];
   assign rsp.point_y      = pt15_ff[1];
   assign rsp.point_z      = pt15_ff[2];

   // a miss carries no distance and no point
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.is_hit |-> rsp.hit_distance == '0 && rsp.point_x == '0
                                   && rsp.point_y == '0 && rsp.point_z == '0)
      else $error("miss beat with nonzero payload");

   // every reported hit lies beyond the epsilon
   a_hit_beyond_eps: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.is_hit |-> rsp.hit_distance > {16'b0, min_dist_ff})
      else $error("hit at or below min_distance");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("rsp valid right after reset");

endmodule
`default_nettype wire

[tb/ray_rectangle_intersect_tb.sv]
`default_nettype none
module ray_rectangle_intersect_tb import rrect_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic ReqPrimary = 1'b0;
   localparam logic ReqShadow  = 1'b1;
   localparam int   DrainCycles = 40;
   localparam int   IdleLimit   = 5000;
   localparam int   LongHold    = 400;

   typedef struct {
      logic      kind;
      coord_type ox, oy, oz;
      coord_type dx, dy, dz;
   } ray_type;

   typedef struct {
      logic             hit;
      logic [DistW-1:0] distance;
      coord_type        px, py, pz;
   } hit_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [2:0] csr_index;
   logic [62:0] csr_wdata;

   rrect_req_if req ();
   rrect_rsp_if rsp ();

   ray_rectangle_intersect dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow copy of the rectangle registers
   logic [XyzW-1:0] rect_corner, rect_edge_a, rect_edge_b, rect_normal;
   logic [LenW-1:0] rect_len_a, rect_len_b;
   logic [EpsW-1:0] rect_min_dist;
   logic            rect_shadow_en;

   ray_type pending_rays[$];
   hit_type expected_hits[$];
   int      errors = 0;
   int      idle_cycles = 0;
   bit      req_taken = 0;
   bit      hold_rsp = 0;
   int      burst_left = 0;
   int      gap_left = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint field_of(input logic [XyzW-1:0] w, input int i);
      coord_type v;
      v = w[(2-i)*CoordW +: CoordW];
      return longint'(v);
   endfunction

   function automatic coord_type clamp21(input longint v);
      if (v < -1048576) v = -1048576;
      if (v > 1048575) v = 1048575;
      return coord_type'(v);
   endfunction

   // plane distance, hit point and edge tests for one ray
   function automatic hit_type trace_ray(input ray_type r);
      hit_type res;
      longint c[3], ea[3], eb[3], nn[3], o[3], d[3], p[3];
      longint num, den, pa, pb, an, ad, t, off;
      res.hit = 1'b0; res.distance = '0; res.px = '0; res.py = '0; res.pz = '0;
      if (r.kind == ReqShadow && !rect_shadow_en) return res;
      o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
      d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
      num = 0; den = 0; pa = 0; pb = 0;
      for (int i = 0; i < 3; i++) begin
         c[i]  = field_of(rect_corner, i);
         ea[i] = field_of(rect_edge_a, i);
         eb[i] = field_of(rect_edge_b, i);
         nn[i] = field_of(rect_normal, i);
         num += (c[i] - o[i]) * nn[i];
         den += d[i] * nn[i];
      end
      if (den == 0 || num == 0 || ((num < 0) != (den < 0))) return res;
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      t = (an <<< 16) / ad;
      if (t > 64'sh0FFFF_FFFF) t = 64'sh0FFFF_FFFF;
      if (t <= longint'(rect_min_dist)) return res;
      for (int i = 0; i < 3; i++) begin
         p[i] = o[i] + ((t * d[i]) >>> 16);
         off = p[i] - c[i];
         pa += off * ea[i];
         pb += off * eb[i];
      end
      if (pa < 0 || pa > longint'(rect_len_a)) return res;
      if (pb < 0 || pb > longint'(rect_len_b)) return res;
      res.hit = 1'b1;
      res.distance = t[31:0];
      if (r.kind == ReqPrimary) begin
         res.px = clamp21(p[0]); res.py = clamp21(p[1]); res.pz = clamp21(p[2]);
      end
      return res;
   endfunction

   function automatic logic [XyzW-1:0] pack_xyz(input longint x, input longint y,
                                               input longint z);
      coord_type a, b, c;
      a = coord_type'(x); b = coord_type'(y); c = coord_type'(z);
      return {a, b, c};
   endfunction

   function automatic logic [62:0] rand63();
      return 63'({$urandom, $urandom});
   endfunction

   // register write, applied at a falling edge
   task automatic csr_write(input logic [2:0] idx, input logic [62:0] val);
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      case (idx)
         RegCorner:     rect_corner    = val;
         RegEdgeA:      rect_edge_a    = val;
         RegEdgeB:      rect_edge_b    = val;
         RegNormal:     rect_normal    = val;
         RegEdgeALenSq: rect_len_a     = val[LenW-1:0];
         RegEdgeBLenSq: rect_len_b     = val[LenW-1:0];
         RegMinDist:    rect_min_dist  = val[EpsW-1:0];
         default:       rect_shadow_en = val[0];
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_rays.size() != 0 || expected_hits.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // axis-aligned rectangle in a z plane, all registers written
   task automatic set_flat_rect(input longint cx, input longint cy, input longint cz,
                                input longint ax, input longint by, input bit flip,
                                input logic [EpsW-1:0] eps, input logic sh);
      csr_write(RegCorner, pack_xyz(cx, cy, cz));
      csr_write(RegEdgeA, pack_xyz(ax, 0, 0));
      csr_write(RegEdgeB, pack_xyz(0, by, 0));
      csr_write(RegNormal, pack_xyz(0, 0, flip ? -(1 << 19) : (1 << 19)));
      csr_write(RegEdgeALenSq, 63'(ax * ax));
      csr_write(RegEdgeBLenSq, 63'(by * by));
      csr_write(RegMinDist, 63'(eps));
      csr_write(RegShadowEn, 63'(sh));
   endtask

   task automatic add_ray(input logic k, input longint ox, input longint oy,
                          input longint oz, input longint dx, input longint dy,
                          input longint dz);
      ray_type r;
      r.kind = k;
      r.ox = coord_type'(ox); r.oy = coord_type'(oy); r.oz = coord_type'(oz);
      r.dx = coord_type'(dx); r.dy = coord_type'(dy); r.dz = coord_type'(dz);
      pending_rays.push_back(r);
   endtask

   // mostly rays aimed at the rectangle, with some noise
   task automatic add_aimed(input int count, input longint cx, input longint cy,
                            input longint cz, input longint ax, input longint by);
      longint tx, ty, ox, oy, oz;
      int sc;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            add_ray(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
         end else begin
            tx = cx + longint'($urandom_range(0, 32'(ax + ax / 8))) - ax / 16;
            ty = cy + longint'($urandom_range(0, 32'(by + by / 8))) - by / 16;
            ox = cx + longint'($urandom_range(0, 65536)) - 32768;
            oy = cy + longint'($urandom_range(0, 65536)) - 32768;
            oz = cz + ($urandom_range(0, 1) ? 64'sd1 : -64'sd1)
                      * longint'($urandom_range(1, 60000));
            sc = int'($urandom_range(0, 2));
            add_ray(1'($urandom_range(0, 1)), ox, oy, oz, (tx - ox) >>> sc,
                    (ty - oy) >>> sc, (cz - oz) >>> sc);
         end
      end
   endtask

   // driver: bursts of beats separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!(req.valid && !req_taken)) begin
         req_taken = 0;
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end
         if (gap_left > 0 && burst_left == 0) begin
            gap_left--;
            req.valid <= 1'b0;
         end else if (pending_rays.size() != 0) begin
            if (burst_left > 0) burst_left--;
            req.valid    <= 1'b1;
            req.req_type <= pending_rays[0].kind;
            req.origin_x <= pending_rays[0].ox;
            req.origin_y <= pending_rays[0].oy;
            req.origin_z <= pending_rays[0].oz;
            req.dir_x    <= pending_rays[0].dx;
            req.dir_y    <= pending_rays[0].dy;
            req.dir_z    <= pending_rays[0].dz;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern in stretches, plus one long hold-off
   int stall_mode = 0;
   int stall_count = 0;
   int hold_count = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_rsp) begin
         rsp.ready <= 1'b0;
         hold_count++;
         if (hold_count >= LongHold) hold_rsp = 0;
      end else begin
         if (stall_count == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_count = $urandom_range(16, 96);
         end
         stall_count--;
         case (stall_mode)
            0:       rsp.ready <= 1'b1;
            1:       rsp.ready <= ($urandom_range(0, 3) != 0);
            default: rsp.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // accepted rays predicted, results checked, watchdog
   always @(posedge clock) begin
      ray_type r;
      hit_type e;
      if (!reset) begin
         idle_cycles++;
         if (req.valid && req.ready) begin
            idle_cycles = 0;
            req_taken = 1;
            r.kind = req.req_type;
            r.ox = req.origin_x; r.oy = req.origin_y; r.oz = req.origin_z;
            r.dx = req.dir_x; r.dy = req.dir_y; r.dz = req.dir_z;
            expected_hits.push_back(trace_ray(r));
            void'(pending_rays.pop_front());
         end
         if (rsp.valid && rsp.ready) begin
            idle_cycles = 0;
            if (expected_hits.size() == 0) begin
               $display("%0t: unexpected result beat", $time);
               errors++;
            end else begin
               e = expected_hits.pop_front();
               if (rsp.is_hit !== e.hit) begin
                  $display("%0t: is_hit exp %0d got %0d", $time, e.hit, rsp.is_hit);
                  errors++;
               end
               if (rsp.hit_distance !== e.distance) begin
                  $display("%0t: hit_distance exp %h got %h", $time, e.distance,
                           rsp.hit_distance);
                  errors++;
               end
               if (rsp.point_x !== e.px || rsp.point_y !== e.py || rsp.point_z !== e.pz)
               begin
                  $display("%0t: point exp %0d %0d %0d got %0d %0d %0d", $time,
                           e.px, e.py, e.pz, rsp.point_x, rsp.point_y, rsp.point_z);
                  errors++;
               end
            end
         end
         if (idle_cycles >= IdleLimit) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      req.valid = 1'b0; req.req_type = ReqPrimary;
      req.origin_x = '0; req.origin_y = '0; req.origin_z = '0;
      req.dir_x = '0; req.dir_y = '0; req.dir_z = '0;
      rsp.ready = 1'b0;
      rect_corner = '0; rect_edge_a = '0; rect_edge_b = '0; rect_normal = '0;
      rect_len_a = '0; rect_len_b = '0;
      rect_min_dist = MinDistReset; rect_shadow_en = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset defaults: zero normal, every ray misses
      add_ray(ReqPrimary, 1000, -1000, 5, 4096, 0, -4096);
      add_ray(ReqShadow, -1048576, 1048575, 0, 1048575, -1048576, 1);
      wait_drained();

      // directed: unit square at z=0, corner at origin
      set_flat_rect(0, 0, 0, 4096, 4096, 0, 66, 1);
      add_ray(ReqPrimary, 2048, 2048, 4096, 0, 0, -4096);     // center hit
      add_ray(ReqShadow, 2048, 2048, 4096, 0, 0, -4096);      // shadow hit
      add_ray(ReqPrimary, 2048, 2048, 4096, 4096, 0, 0);      // parallel
      add_ray(ReqPrimary, 2048, 2048, 4096, 0, 0, 4096);      // behind
      add_ray(ReqPrimary, 2048, 2048, 0, 0, 0, -4096);        // on plane
      add_ray(ReqPrimary, 0, 0, 4096, 0, 0, -4096);           // corner
      add_ray(ReqPrimary, 4096, 4096, 4096, 0, 0, -4096);     // far corner
      add_ray(ReqPrimary, 4097, 2048, 4096, 0, 0, -4096);     // just outside a
      add_ray(ReqPrimary, 2048, -1, 4096, 0, 0, -4096);       // just outside b
      add_ray(ReqPrimary, 2048, 2048, 4, 0, 0, -1048576);     // t under epsilon
      add_ray(ReqPrimary, 2048, 2048, 1048575, 0, 0, -1);     // saturated t
      add_ray(ReqPrimary, 2048, 2048, -1048576, 0, 0, 1);
      add_ray(ReqPrimary, 1048575, 1048575, 1048575, -1048576, -1048576, -1048576);
      add_ray(ReqShadow, -1048576, -1048576, -1048576, 1048575, 1048575, 1048575);
      add_ray(ReqPrimary, 2048, 2048, 1048575, 1048575, 1048575, -1048576);
      wait_drained();

      // shadows off, epsilon zero
      set_flat_rect(0, 0, 0, 4096, 4096, 1, 0, 0);
      add_ray(ReqShadow, 2048, 2048, 4096, 0, 0, -4096);
      add_ray(ReqPrimary, 2048, 2048, 4096, 0, 0, -4096);
      add_ray(ReqPrimary, 2048, 2048, 1, 0, 0, -1048576);
      add_aimed(60, 0, 0, 0, 4096, 4096);
      wait_drained();

      // long receiver hold-off while the sender keeps offering
      set_flat_rect(-20000, 30000, 12000, 16000, 9000, 0, 65535, 1);
      add_aimed(150, -20000, 30000, 12000, 16000, 9000);
      hold_rsp = 1;
      wait_drained();

      // largest squared lengths and an off-axis normal, random content
      csr_write(RegEdgeALenSq, 63'hFF_FFFF_FFFF);
      csr_write(RegEdgeBLenSq, 63'hFF_FFFF_FFFF);
      csr_write(RegNormal, pack_xyz(370727, -370727, 370727));
      csr_write(RegMinDist, 63'd1);
      add_aimed(100, -20000, 30000, 12000, 16000, 9000);
      wait_drained();

      // fully random registers
      for (int ph = 0; ph < 3; ph++) begin
         csr_write(RegCorner, rand63());
         csr_write(RegEdgeA, rand63());
         csr_write(RegEdgeB, rand63());
         csr_write(RegNormal, rand63());
         csr_write(RegEdgeALenSq, rand63());
         csr_write(RegEdgeBLenSq, rand63());
         csr_write(RegMinDist, rand63());
         csr_write(RegShadowEn, rand63());
         for (int i = 0; i < 40; i++)
            add_ray(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
         wait_drained();
      end

      // several more well-formed rectangles
      for (int ph = 0; ph < 4; ph++) begin
         longint cx, cy, cz, ax, by;
         cx = longint'($urandom_range(0, 200000)) - 100000;
         cy = longint'($urandom_range(0, 200000)) - 100000;
         cz = longint'($urandom_range(0, 200000)) - 100000;
         ax = longint'($urandom_range(512, 30000));
         by = longint'($urandom_range(512, 30000));
         set_flat_rect(cx, cy, cz, ax, by, 1'($urandom_range(0, 1)),
                       EpsW'($urandom_range(0, 2000)), 1'($urandom_range(0, 1)));
         add_aimed(90, cx, cy, cz, ax, by);
         wait_drained();
      end

      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
